// ----- hw/rtl/vpiu_pkg.sv -----
// Shared types and constants for the vector permute and integer unit.
// No dependencies.
package vpiu_pkg;

  typedef enum logic [4:0] {
    ACT_AND = 5'd0, ACT_ANDC = 5'd1, ACT_OR = 5'd2, ACT_NOR = 5'd3, ACT_XOR = 5'd4,
    ACT_MAXUW = 5'd5, ACT_MINUW = 5'd6, ACT_MRGHW = 5'd7, ACT_MRGLW = 5'd8,
    ACT_SPLTW = 5'd9, ACT_SPLTB = 5'd10, ACT_SPLTISH = 5'd11, ACT_SPLTISW = 5'd12,
    ACT_SPLTISB = 5'd13, ACT_PERM = 5'd14, ACT_SLDOI = 5'd15, ACT_SLB = 5'd16,
    ACT_SLW = 5'd17, ACT_SRW = 5'd18, ACT_SR = 5'd19
  } action_t;

  typedef struct packed {
    logic [4:0]  action;
    logic [63:0] vec_a_hi;
    logic [63:0] vec_a_lo;
    logic [63:0] vec_b_hi;
    logic [63:0] vec_b_lo;
    logic [63:0] vec_c_hi;
    logic [63:0] vec_c_lo;
    logic [4:0]  imm_five;
  } vpiu_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } vpiu_out_t;

  typedef enum logic [1:0] {
    CLS_LOGIC = 2'd0, CLS_WORD = 2'd1, CLS_PERM = 2'd2, CLS_NONE = 2'd3
  } op_class_t;

  typedef struct packed {
    op_class_t   cls;
    logic [4:0]  action;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] c;
    logic [4:0]  imm;
  } vpiu_op_t;

  localparam int unsigned QueueDepth = 2;

endpackage

// ----- hw/rtl/vpiu_front.sv -----
// Front end: accepts commands, classifies them, and holds them in a short queue.
// Depends on vpiu_pkg.
module vpiu_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  vpiu_pkg::vpiu_in_t cmd,
  output logic               op_valid,
  input  logic               op_ready,
  output vpiu_pkg::vpiu_op_t op
);
  import vpiu_pkg::*;

  vpiu_op_t   queue [QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  vpiu_op_t   op_next;
  logic       push;
  logic       pop;

  always_comb begin
    op_next.action = cmd.action;
    op_next.a      = {cmd.vec_a_hi, cmd.vec_a_lo};
    op_next.b      = {cmd.vec_b_hi, cmd.vec_b_lo};
    op_next.c      = {cmd.vec_c_hi, cmd.vec_c_lo};
    op_next.imm    = cmd.imm_five;
    if (cmd.action inside {[ACT_AND:ACT_XOR]}) begin
      op_next.cls = CLS_LOGIC;
    end else if (cmd.action inside {ACT_MAXUW, ACT_MINUW, ACT_SLW, ACT_SRW}) begin
      op_next.cls = CLS_WORD;
    end else if (cmd.action inside {[ACT_MRGHW:ACT_SLB], ACT_SR}) begin
      op_next.cls = CLS_PERM;
    end else begin
      op_next.cls = CLS_NONE;
    end
  end

  assign busy     = (count == 2'(QueueDepth));
  assign push     = start && !busy;
  assign op_valid = (count != 2'd0);
  assign pop      = op_valid && op_ready;
  assign op       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= op_next;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/vpiu_back.sv -----
// Back end: executes one queued operation per cycle into a result register.
// Depends on vpiu_pkg.
module vpiu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_ready,
  input  vpiu_pkg::vpiu_op_t  op,
  output logic                done,
  output vpiu_pkg::vpiu_out_t result
);
  import vpiu_pkg::*;

  logic [127:0] d;
  logic [7:0]   ab [16];
  logic [7:0]   bb [16];
  logic [7:0]   cb [16];
  logic [7:0]   cat [32];
  logic [31:0]  aw [4];
  logic [31:0]  bw [4];
  logic [31:0]  sx;
  logic [5:0]   k;

  assign op_ready = 1'b1;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      ab[i]      = op.a[127-8*i -: 8];
      bb[i]      = op.b[127-8*i -: 8];
      cb[i]      = op.c[127-8*i -: 8];
      cat[i]     = ab[i];
      cat[16+i]  = bb[i];
    end
    for (int i = 0; i < 4; i++) begin
      aw[i] = op.a[127-32*i -: 32];
      bw[i] = op.b[127-32*i -: 32];
    end
    sx = {{27{op.imm[4]}}, op.imm};
    d  = '0;
    k  = '0;
    case (action_t'(op.action))
      ACT_AND:  d = op.a & op.b;
      ACT_ANDC: d = op.a & ~op.b;
      ACT_OR:   d = op.a | op.b;
      ACT_NOR:  d = ~(op.a | op.b);
      ACT_XOR:  d = op.a ^ op.b;
      ACT_MAXUW, ACT_MINUW:
        for (int i = 0; i < 4; i++) begin
          d[127-32*i -: 32] = ((aw[i] >= bw[i]) == (op.action == ACT_MAXUW)) ?
                              aw[i] : bw[i];
          if (op.action == ACT_MINUW && aw[i] == bw[i]) d[127-32*i -: 32] = aw[i];
        end
      ACT_MRGHW: d = {aw[0], bw[0], aw[1], bw[1]};
      ACT_MRGLW: d = {aw[2], bw[2], aw[3], bw[3]};
      ACT_SPLTW: d = {4{bw[op.imm[1:0]]}};
      ACT_SPLTB: d = {16{bb[op.imm[3:0]]}};
      ACT_SPLTISH: d = {8{sx[15:0]}};
      ACT_SPLTISW: d = {4{sx}};
      ACT_SPLTISB: d = {16{sx[7:0]}};
      ACT_PERM:
        for (int i = 0; i < 16; i++) d[127-8*i -: 8] = cat[cb[i][4:0]];
      ACT_SLDOI:
        for (int i = 0; i < 16; i++) begin
          k = 6'(op.imm) + 6'(i);
          d[127-8*i -: 8] = k[5] ? 8'd0 : cat[k[4:0]];
        end
      ACT_SLB:
        for (int i = 0; i < 16; i++) d[127-8*i -: 8] = ab[i] << bb[i][2:0];
      ACT_SLW:
        for (int i = 0; i < 4; i++) d[127-32*i -: 32] = aw[i] << bw[i][4:0];
      ACT_SRW:
        for (int i = 0; i < 4; i++) d[127-32*i -: 32] = aw[i] >> bw[i][4:0];
      ACT_SR: d = op.a >> bb[15][2:0];
      default: d = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      result <= {d[127:64], d[63:0]};
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= op_valid;
    end
  end

endmodule

// ----- hw/rtl/vector_permute_integer_unit.sv -----
// Top level of the vector permute and integer unit.
// Depends on vpiu_pkg, vpiu_front and vpiu_back.
//
// Command channel: an instruction (cmd) is taken at a rising edge with
// start high and busy low. Each accepted instruction gives one transaction
// on the result channel: done is high for exactly one cycle with result.
// From accept to done an instruction passes through the front queue and then
// the execute register. Throughput: one instruction per cycle; busy stays
// low in normal use since the back end drains one entry every cycle.
// The front end holds up to two classified instructions in a queue; the
// back end is combinational logic, compare, shift and byte/word selection into a result register.
// Reset clears the queue and the done strobe. The receiver cannot stall:
// each result is presented for its single cycle only.
module vector_permute_integer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  vpiu_pkg::vpiu_in_t  cmd,
  output logic                done,
  output vpiu_pkg::vpiu_out_t result
);
  import vpiu_pkg::*;

  vpiu_op_t op;
  logic     op_valid;
  logic     op_ready;

  vpiu_front u_front (
    .clk, .rst, .start, .busy, .cmd,
    .op_valid, .op_ready, .op
  );

  vpiu_back u_back (
    .clk, .rst, .op_valid, .op_ready, .op, .done, .result
  );

endmodule

// ----- test/tb_vector_permute_integer_unit.sv -----
// Testbench for vector_permute_integer_unit: directed table, then random instructions,
// each result checked against a typed row or an in-bench predictor. Depends on vpiu_pkg.
module tb_vector_permute_integer_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vpiu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  vpiu_in_t cmd = '0;
  vpiu_out_t result;
  int errors = 0;
  vpiu_out_t expected_q[$];

  vector_permute_integer_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] byte_of(logic [127:0] v, int i);
    return v[127 - 8 * i -: 8];
  endfunction

  function automatic logic [31:0] word_of(logic [127:0] v, int i);
    return v[127 - 32 * i -: 32];
  endfunction

  function automatic vpiu_out_t compute_vector(vpiu_in_t t);
    logic [127:0] a, b, c, d;
    logic [255:0] ab;
    logic [31:0] s, x, y;
    logic [7:0] bsel;
    int k;
    a = {t.vec_a_hi, t.vec_a_lo};
    b = {t.vec_b_hi, t.vec_b_lo};
    c = {t.vec_c_hi, t.vec_c_lo};
    d = '0;
    s = {{27{t.imm_five[4]}}, t.imm_five};
    case (t.action)
      ACT_AND: d = a & b;
      ACT_ANDC: d = a & ~b;
      ACT_OR: d = a | b;
      ACT_NOR: d = ~(a | b);
      ACT_XOR: d = a ^ b;
      ACT_MAXUW, ACT_MINUW: begin
        for (int i = 0; i < 4; i++) begin
          x = word_of(a, i);
          y = word_of(b, i);
          if (t.action == ACT_MAXUW) d[127 - 32 * i -: 32] = (x >= y) ? x : y;
          else d[127 - 32 * i -: 32] = (x < y) ? x : y;
        end
      end
      ACT_MRGHW, ACT_MRGLW: begin
        k = (t.action == ACT_MRGHW) ? 0 : 2;
        d = {word_of(a, k), word_of(b, k), word_of(a, k + 1), word_of(b, k + 1)};
      end
      ACT_SPLTW: d = {4{word_of(b, t.imm_five[1:0])}};
      ACT_SPLTB: d = {16{byte_of(b, t.imm_five[3:0])}};
      ACT_SPLTISH: d = {8{s[15:0]}};
      ACT_SPLTISW: d = {4{s}};
      ACT_SPLTISB: d = {16{s[7:0]}};
      ACT_PERM: begin
        ab = {a, b};
        for (int i = 0; i < 16; i++) begin
          bsel = byte_of(c, i);
          d[127 - 8 * i -: 8] = ab[255 - 8 * bsel[4:0] -: 8];
        end
      end
      ACT_SLDOI: begin
        ab = {a, b};
        ab = ab << (8 * t.imm_five);
        d = ab[255:128];
      end
      ACT_SLB: begin
        for (int i = 0; i < 16; i++) begin
          bsel = byte_of(b, i);
          d[127 - 8 * i -: 8] = byte_of(a, i) << bsel[2:0];
        end
      end
      ACT_SLW, ACT_SRW: begin
        for (int i = 0; i < 4; i++) begin
          x = word_of(a, i);
          y = word_of(b, i);
          if (t.action == ACT_SLW) d[127 - 32 * i -: 32] = x << y[4:0];
          else d[127 - 32 * i -: 32] = x >> y[4:0];
        end
      end
      ACT_SR: d = a >> b[2:0];
      default: d = '0;
    endcase
    return {d[127:64], d[63:0]};
  endfunction

  function automatic vpiu_in_t random_cmd();
    vpiu_in_t t;
    t.vec_a_hi = {$urandom, $urandom};
    t.vec_a_lo = {$urandom, $urandom};
    t.vec_b_hi = {$urandom, $urandom};
    t.vec_b_lo = {$urandom, $urandom};
    t.vec_c_hi = {$urandom, $urandom};
    t.vec_c_lo = {$urandom, $urandom};
    t.imm_five = 5'($urandom_range(0, 31));
    t.action = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31)) :
                                              5'($urandom_range(0, 19));
    if ($urandom_range(0, 9) == 0) begin
      t.vec_a_hi = '1; t.vec_a_lo = '1;
      t.vec_b_hi = ($urandom_range(0, 1) != 0) ? '1 : '0;
      t.vec_b_lo = t.vec_b_hi;
    end
    return t;
  endfunction

  typedef struct {
    vpiu_in_t  stim;
    bit        typed;
    vpiu_out_t want;
  } table_row_t;

  table_row_t rows[$];

  // Enter at a falling edge; leave at a falling edge with start still high
  // only when the next transaction follows with no gap.
  task automatic issue(vpiu_in_t t);
    int gap;
    bit accepted;
    cmd <= t;
    start <= 1'b1;
    forever begin
      accepted = !busy;
      @(posedge clk);
      if (accepted) break;
      @(negedge clk);
    end
    @(negedge clk);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      automatic vpiu_out_t w;
      w = compute_vector(cmd);
      for (int i = 0; i < rows.size(); i++)
        if (rows[i].typed && rows[i].stim == cmd) w = rows[i].want;
      expected_q.push_back(w);
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding: %h", result);
        errors++;
      end else begin
        automatic vpiu_out_t w = expected_q.pop_front();
        if (result.result_hi !== w.result_hi) begin
          $error("result_hi expected %h actual %h", w.result_hi, result.result_hi);
          errors++;
        end
        if (result.result_lo !== w.result_lo) begin
          $error("result_lo expected %h actual %h", w.result_lo, result.result_lo);
          errors++;
        end
      end
    end
  end

  function automatic vpiu_in_t mk(action_t act, logic [127:0] a, logic [127:0] b,
                                  logic [127:0] c, logic [4:0] imm);
    vpiu_in_t t;
    t.action = act;
    {t.vec_a_hi, t.vec_a_lo} = a;
    {t.vec_b_hi, t.vec_b_lo} = b;
    {t.vec_c_hi, t.vec_c_lo} = c;
    t.imm_five = imm;
    return t;
  endfunction

  task automatic add_row(vpiu_in_t t, bit typed, logic [127:0] w);
    table_row_t r;
    r.stim = t;
    r.typed = typed;
    r.want = {w[127:64], w[63:0]};
    rows.push_back(r);
  endtask

  localparam logic [127:0] Ones = '1;
  localparam logic [127:0] Seq = 128'h000102030405060708090a0b0c0d0e0f;
  localparam logic [127:0] SeqB = 128'h101112131415161718191a1b1c1d1e1f;

  initial begin
    int wait_cycles;
    add_row(mk(ACT_AND, Ones, Ones, '0, 5'd0), 1, Ones);
    add_row(mk(ACT_ANDC, Ones, Ones, '0, 5'd0), 1, '0);
    add_row(mk(ACT_OR, '0, '0, Ones, 5'd31), 1, '0);
    add_row(mk(ACT_NOR, '0, '0, '0, 5'd0), 1, Ones);
    add_row(mk(ACT_XOR, Ones, Seq, '0, 5'd0), 1, ~Seq);
    add_row(mk(ACT_MAXUW, Ones, '0, '0, 5'd0), 1, Ones);
    add_row(mk(ACT_MINUW, Ones, '0, '0, 5'd0), 1, '0);
    add_row(mk(ACT_MRGHW, Seq, SeqB, '0, 5'd0), 0, '0);
    add_row(mk(ACT_MRGLW, Seq, SeqB, '0, 5'd0), 0, '0);
    add_row(mk(ACT_SPLTW, '0, Seq, '0, 5'd7), 1, {4{32'h0c0d0e0f}});
    add_row(mk(ACT_SPLTB, '0, Seq, '0, 5'd31), 1, {16{8'h0f}});
    add_row(mk(ACT_SPLTISH, '0, '0, '0, 5'd16), 1, {8{16'hfff0}});
    add_row(mk(ACT_SPLTISW, '0, '0, '0, 5'd15), 1, {4{32'h0000000f}});
    add_row(mk(ACT_SPLTISB, '0, '0, '0, 5'd31), 1, Ones);
    add_row(mk(ACT_PERM, Seq, SeqB, Seq | {16{8'he0}}, 5'd0), 1, Seq);
    add_row(mk(ACT_PERM, Seq, SeqB, ~Seq, 5'd0), 0, '0);
    add_row(mk(ACT_SLDOI, Seq, SeqB, '0, 5'd0), 1, Seq);
    add_row(mk(ACT_SLDOI, Seq, SeqB, '0, 5'd16), 1, SeqB);
    add_row(mk(ACT_SLDOI, Seq, SeqB, '0, 5'd31), 1, {8'h1f, 120'h0});
    add_row(mk(ACT_SLB, Ones, Ones, '0, 5'd0), 1, {16{8'h80}});
    add_row(mk(ACT_SLW, Ones, Ones, '0, 5'd0), 1, {4{32'h80000000}});
    add_row(mk(ACT_SRW, Ones, Ones, '0, 5'd0), 1, {4{32'h00000001}});
    add_row(mk(ACT_SR, Ones, 128'h7, '0, 5'd0), 1, Ones >> 7);
    add_row(mk(ACT_SR, Seq, ~128'h7, '0, 5'd0), 1, Seq);
    add_row(mk(action_t'(5'd31), Ones, Ones, Ones, 5'd31), 1, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) issue(rows[i].stim);
    repeat (650) issue(random_cmd());
    start <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (5) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/vpiu_pkg.sv
hw/rtl/vpiu_front.sv
hw/rtl/vpiu_back.sv
hw/rtl/vector_permute_integer_unit.sv
test/tb_vector_permute_integer_unit.sv
